// ----- rtl/core/hbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hbp_pkg
// Shared types and fixed field widths of the Huffman bit packer.
// ----------------------------------------------------------------------------
package hbp_pkg;

    localparam int ACTION_W    = 2;
    localparam int SYMBOL_W    = 9;
    localparam int CODE_BITS_W = 32;
    localparam int CODE_LEN_W  = 6;
    localparam int BYTE_W      = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

endpackage

// ----- rtl/core/hbp_in_if.sv -----
// ----------------------------------------------------------------------------
// hbp_in_if
// Input channel of the bit packer: action, symbol and code entry.
// ----------------------------------------------------------------------------
interface hbp_in_if;
    import hbp_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_BITS_W-1:0] code_bits;
    logic [CODE_LEN_W-1:0]  code_length;

    modport source (output valid, action, symbol, code_bits, code_length, input ready);
    modport sink   (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

// ----- rtl/core/hbp_out_if.sv -----
// ----------------------------------------------------------------------------
// hbp_out_if
// Output channel of the bit packer: one packed byte per transfer.
// ----------------------------------------------------------------------------
interface hbp_out_if;
    import hbp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

// ----- rtl/core/huffman_bit_packer_core.sv -----
// ----------------------------------------------------------------------------
// huffman_bit_packer_core
// Byte-stream Huffman encoder: code table lookup and LSB-first bit packing.
// ----------------------------------------------------------------------------
// usage
//   input channel: load items write one code table entry (code and length),
//   encode items append the code of their byte, a finish item appends the
//   end-of-stream code and flushes any partial byte.
//   output channel: one packed byte per transfer, earliest code bit in bit 0,
//   last set on the final byte caused by an input item.
//   path: each item passes the table read, then is packed into the output buffer.
//   throughput: one input transfer per cycle while items produce at most one
//   byte and the receiver is ready; an item producing several bytes holds the
//   next item until its last byte is taken, since the output buffer drains one
//   byte per cycle while the receiver is ready (up to five for a finish).
//   reset clears pending bits and the pipeline; table contents are kept and
//   are valid only for entries loaded since power-up.
//   when the receiver stalls, the output buffer holds, the lookup stage waits
//   behind it and ready drops on the input channel once that stage is full.
// ----------------------------------------------------------------------------
module huffman_bit_packer_core #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOL_COUNT = 257
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hbp_in_if.sink    i_in,
    hbp_out_if.source o_out
);
    import hbp_pkg::*;

    localparam int CODE_W = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
    localparam int LEN_W  = $clog2(CODE_W + 1);
    localparam int ACC_W  = CODE_W + BYTE_W;
    localparam int TOT_W  = $clog2(CODE_W + BYTE_W);
    localparam int MAXB   = (CODE_W + 7) / 8 + 1;
    localparam int CNT_W  = $clog2(MAXB + 1);
    localparam int ADDR_W = $clog2(SYMBOL_COUNT);
    localparam int RAM_W  = LEN_W + CODE_W;

    logic              in_xfer, out_xfer;
    logic              sym_ok, do_load, do_enc, do_fin, rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [LEN_W-1:0]  ld_len;
    logic [CODE_W-1:0] ld_code;
    logic [RAM_W-1:0]  rd_data;
    logic [CODE_W-1:0] s1_code;
    logic [LEN_W-1:0]  s1_len;
    logic [ACC_W-1:0]  acc, shifted;
    logic [TOT_W-1:0]  total;
    logic [CNT_W-1:0]  nbytes;
    logic              s1_go;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_fin;
    logic [2:0]        r_pcount;
    logic [BYTE_W-1:0] r_pbyte;
    logic [ACC_W-1:0]  r_buf;
    logic [CNT_W-1:0]  r_cnt;

    // input decode
    assign in_xfer = i_in.valid && i_in.ready;
    assign sym_ok  = (i_in.symbol < SYMBOL_W'(SYMBOL_COUNT));

    always_comb begin
        do_load = 1'b0;
        do_enc  = 1'b0;
        do_fin  = 1'b0;
        unique case (t_action'(i_in.action))
            ACT_LOAD:   do_load = sym_ok;
            ACT_ENCODE: do_enc  = sym_ok;
            ACT_FINISH: do_fin  = 1'b1;
            default:    ;
        endcase
    end

    assign ld_len  = (i_in.code_length > CODE_LEN_W'(CODE_W)) ? LEN_W'(CODE_W)
                                                              : i_in.code_length[LEN_W-1:0];
    assign ld_code = i_in.code_bits[CODE_W-1:0] & ~({CODE_W{1'b1}} << ld_len);
    assign rd_en   = in_xfer && (do_enc || do_fin);
    assign rd_addr = do_fin ? ADDR_W'(SYMBOL_COUNT - 1) : i_in.symbol[ADDR_W-1:0];

    hbp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (in_xfer && do_load),
        .i_wr_addr (i_in.symbol[ADDR_W-1:0]),
        .i_wr_data ({ld_len, ld_code}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // packing
    assign s1_code = rd_data[CODE_W-1:0];
    assign s1_len  = rd_data[RAM_W-1:CODE_W];
    assign acc     = ACC_W'(r_pbyte) | (ACC_W'(s1_code) << r_pcount);
    assign total   = TOT_W'(r_pcount) + TOT_W'(s1_len);
    assign shifted = acc >> {total[TOT_W-1:3], 3'b000};
    assign nbytes  = CNT_W'(total[TOT_W-1:3]) + CNT_W'(r_s1_fin && (total[2:0] != 3'd0));

    assign s1_go      = r_s1_valid && ((r_cnt == '0) || ((r_cnt == CNT_W'(1)) && o_out.ready));
    assign i_in.ready = !r_s1_valid || s1_go;
    assign n_s1_valid = rd_en || (r_s1_valid && !s1_go);

    assign o_out.valid    = (r_cnt != '0);
    assign o_out.out_byte = r_buf[BYTE_W-1:0];
    assign o_out.last     = (r_cnt == CNT_W'(1));
    assign out_xfer       = o_out.valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_pcount   <= 3'd0;
            r_pbyte    <= '0;
            r_cnt      <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (s1_go) begin
                r_cnt <= nbytes;
                if (r_s1_fin) begin
                    r_pcount <= 3'd0;
                    r_pbyte  <= '0;
                end else begin
                    r_pcount <= total[2:0];
                    r_pbyte  <= shifted[BYTE_W-1:0];
                end
            end else if (out_xfer) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_fin <= do_fin;
        end
        if (s1_go) begin
            r_buf <= acc;
        end else if (out_xfer) begin
            r_buf <= r_buf >> BYTE_W;
        end
    end

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAXB))
        else $error("output buffer count out of range");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_s1_valid && o_out.valid))
        else $error("input stalled without pending work");

    a_fin_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && r_s1_fin) |=> (r_pcount == 3'd0 && r_pbyte == '0))
        else $error("finish did not clear pending bits");

    a_last_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.last && !s1_go) |=> !o_out.valid)
        else $error("bytes left after last transfer");

    a_pbyte_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount == 3'd0) |-> (r_pbyte == '0))
        else $error("stale bits in empty pending byte");
endmodule

// ----- rtl/core/hbp_ram.sv -----
// ----------------------------------------------------------------------------
// hbp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 257
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule
